FILE: src/adnp_pkg.sv
// Shared types and constants for the ASCII decimal number parser.
// Used by the front, queue, back and top-level modules; depends on nothing.
package adnp_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int MAX_DIGITS_DEF = 18;
	localparam int OUT_BITS_DEF   = 32;

	// Mantissa holds up to 18 decimal digits
	localparam int MANT_W = 60;
	// Power-of-ten exponent handed to the back end, -191..190
	localparam int PEXP_W = 9;
	// Scaling register: mantissa plus up to 36 fraction bits, whole chunks
	localparam int CHUNK_W = 12;
	localparam int CHUNKS  = 8;
	localparam int VAL_W   = CHUNK_W * CHUNKS;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_LOW_E = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;

	// One closed number, waiting for scaling
	typedef struct packed {
		logic                     neg;
		logic [MANT_W-1:0]        mant;
		logic signed [PEXP_W-1:0] pexp;
		logic                     fp;
	} rec_t;

endpackage

FILE: src/adnp_front.sv
// Front end: accepts text bytes, tracks the number grammar, collects digits.
// Pushes one record per closed number to the queue. Depends on adnp_pkg.
module adnp_front #(
	parameter int MAX_DIGITS = adnp_pkg::MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               integer_only,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         character,
	input  logic               end_of_text,
	input  logic               q_full,
	output logic               q_push,
	output adnp_pkg::rec_t     q_rec
);

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_INT  = 5'b00010,
		PH_FRAC = 5'b00100,
		PH_EXPS = 5'b01000,
		PH_EXPD = 5'b10000
	} phase_t;

	phase_t                         phase_q, ph_d;
	logic                           neg_q, neg_d;
	logic [adnp_pkg::MANT_W-1:0]    mant_q, mant_d, tk_mant, mant10;
	logic [4:0]                     cnt_q, cnt_d, tk_cnt;
	logic signed [6:0]              sh_q, sh_d, tk_sh, sh_inc, sh_dec;
	logic [6:0]                     ex_q, ex_d, ex_take;
	logic [10:0]                    ex10;
	logic                           en_q, en_d;
	logic                           accept, fl, dig, expc, frac, close;
	logic [3:0]                     d;
	logic signed [adnp_pkg::PEXP_W-1:0] ex_s;

	assign char_stall = q_full;
	assign accept     = char_valid && !q_full;
	assign fl         = !integer_only;
	assign dig        = (character >= adnp_pkg::CH_ZERO) && (character <= adnp_pkg::CH_NINE);
	assign d          = 4'(character - adnp_pkg::CH_ZERO);
	assign expc       = fl && (character == adnp_pkg::CH_LOW_E || character == adnp_pkg::CH_UP_E);
	assign frac       = (phase_q == PH_FRAC);

	assign sh_inc = (sh_q == 7'sd63) ? sh_q : sh_q + 7'sd1;
	assign sh_dec = (sh_q == -7'sd64) ? sh_q : sh_q - 7'sd1;
	assign mant10 = (mant_q << 3) + (mant_q << 1) + adnp_pkg::MANT_W'(d);
	assign ex10   = (11'(ex_q) << 3) + (11'(ex_q) << 1) + 11'(d);
	assign ex_take = (ex10 > 11'd127) ? 7'd127 : ex10[6:0];

	// digit effect on mantissa, count and shift
	always_comb begin
		tk_mant = mant_q;
		tk_cnt  = cnt_q;
		tk_sh   = sh_q;
		if (mant_q == '0 && d == 4'd0) begin
			if (frac) tk_sh = sh_dec;
		end else if (cnt_q < 5'(MAX_DIGITS)) begin
			tk_mant = mant10;
			tk_cnt  = cnt_q + 5'd1;
			if (frac) tk_sh = sh_dec;
		end else if (!frac) begin
			tk_sh = sh_inc;
		end
	end

	always_comb begin
		ph_d   = phase_q;
		neg_d  = neg_q;
		mant_d = mant_q;
		cnt_d  = cnt_q;
		sh_d   = sh_q;
		ex_d   = ex_q;
		en_d   = en_q;
		close  = 1'b0;
		if (end_of_text) begin
			close = (phase_q != PH_IDLE);
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (dig) begin
						ph_d = PH_INT; mant_d = tk_mant; cnt_d = tk_cnt; sh_d = tk_sh;
					end else if (character == adnp_pkg::CH_MINUS) begin
						ph_d = PH_INT; neg_d = 1'b1;
					end else if (fl && character == adnp_pkg::CH_POINT) begin
						ph_d = PH_FRAC;
					end
				end
				PH_INT: begin
					if (dig) begin
						mant_d = tk_mant; cnt_d = tk_cnt; sh_d = tk_sh;
					end else if (fl && character == adnp_pkg::CH_POINT) begin
						ph_d = PH_FRAC;
					end else if (expc) begin
						ph_d = PH_EXPS;
					end else begin
						close = 1'b1;
					end
				end
				PH_FRAC: begin
					if (dig) begin
						mant_d = tk_mant; cnt_d = tk_cnt; sh_d = tk_sh;
					end else if (expc) begin
						ph_d = PH_EXPS;
					end else begin
						close = 1'b1;
					end
				end
				PH_EXPS: begin
					if (dig) begin
						ph_d = PH_EXPD; ex_d = ex_take;
					end else if (character == adnp_pkg::CH_MINUS) begin
						ph_d = PH_EXPD; en_d = 1'b1;
					end else if (character == adnp_pkg::CH_PLUS) begin
						ph_d = PH_EXPD;
					end else begin
						close = 1'b1;
					end
				end
				PH_EXPD: begin
					if (dig) ex_d = ex_take;
					else     close = 1'b1;
				end
				default: begin
					ph_d = PH_IDLE;
				end
			endcase
		end
		// drop the number once it is handed on
		if (close || ph_d == PH_IDLE) begin
			ph_d   = PH_IDLE;
			neg_d  = 1'b0;
			mant_d = '0;
			cnt_d  = '0;
			sh_d   = '0;
			ex_d   = '0;
			en_d   = 1'b0;
		end
	end

	assign ex_s       = $signed({2'b00, ex_q});
	assign q_push     = accept && close;
	assign q_rec.neg  = neg_q;
	assign q_rec.mant = mant_q;
	assign q_rec.pexp = $signed({{2{sh_q[6]}}, sh_q}) + (en_q ? -ex_s : ex_s);
	assign q_rec.fp   = fl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			mant_q  <= '0;
			cnt_q   <= '0;
			sh_q    <= '0;
			ex_q    <= '0;
			en_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= ph_d;
			neg_q   <= neg_d;
			mant_q  <= mant_d;
			cnt_q   <= cnt_d;
			sh_q    <= sh_d;
			ex_q    <= ex_d;
			en_q    <= en_d;
		end
	end

endmodule

FILE: src/adnp_queue.sv
// Two-entry queue of closed-number records between front and back end.
// Depends on adnp_pkg for the record type.
module adnp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  adnp_pkg::rec_t push_rec,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output adnp_pkg::rec_t pop_rec
);

	adnp_pkg::rec_t mem_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_rec   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: src/adnp_back.sv
// Back end: scales each record by its power of ten, one step per cycle,
// saturates and drives the result register. Depends on adnp_pkg.
module adnp_back #(
	parameter int FRAC_BITS = adnp_pkg::FRAC_BITS_DEF,
	parameter int OUT_BITS  = adnp_pkg::OUT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_not_empty,
	input  adnp_pkg::rec_t             q_rec,
	output logic                       q_pop,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [OUT_BITS-1:0] value,
	output logic                       saturated
);

	localparam int VW = adnp_pkg::VAL_W;
	localparam int CW = adnp_pkg::CHUNK_W;
	localparam logic [VW-1:0] LIM_NEG    = VW'(1) << (OUT_BITS - 1);
	localparam logic [VW-1:0] LIM_POS    = LIM_NEG - VW'(1);
	localparam logic [VW-1:0] LIM_NEG_10 = LIM_NEG / 10;
	localparam logic [VW-1:0] LIM_POS_10 = LIM_POS / 10;
	localparam logic [VW-1:0] LIM_NEG_FB = LIM_NEG >> FRAC_BITS;
	localparam logic [VW-1:0] LIM_POS_FB = LIM_POS >> FRAC_BITS;

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_UP   = 6'b000010,
		B_FIT  = 6'b000100,
		B_DOWN = 6'b001000,
		B_CHK  = 6'b010000,
		B_OUT  = 6'b100000
	} bst_t;

	bst_t             st_q;
	logic [VW-1:0]    v_q, lim, lim10, limfit, mag;
	logic             neg_q, fp_q, sat_q;
	logic [7:0]       k_q;
	logic [2:0]       ch_q;
	logic [3:0]       rem_q, r;
	logic [15:0]      x;
	logic [31:0]      prod;
	logic [CW-1:0]    q;
	logic             load;
	logic [OUT_BITS-1:0] mag_o;

	assign lim    = neg_q ? LIM_NEG : LIM_POS;
	assign lim10  = neg_q ? LIM_NEG_10 : LIM_POS_10;
	assign limfit = fp_q ? (neg_q ? LIM_NEG_FB : LIM_POS_FB) : lim;

	// one 12-bit chunk of a divide by ten, remainder carried down
	assign x    = {rem_q, v_q[VW-1 -: CW]};
	assign prod = 32'(x) * 32'd52429;
	assign q    = prod[19 +: CW];
	assign r    = 4'(x - 16'((q << 3) + (q << 1)));

	assign q_pop = (st_q == B_IDLE) && q_not_empty;
	assign load  = (st_q == B_OUT) && (!result_valid || !result_stall);
	assign mag   = sat_q ? lim : v_q;
	assign mag_o = mag[OUT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_IDLE;
			neg_q <= 1'b0;
			fp_q  <= 1'b0;
			sat_q <= 1'b0;
			k_q   <= '0;
			ch_q  <= '0;
			rem_q <= '0;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (q_not_empty) begin
						neg_q <= q_rec.neg;
						fp_q  <= q_rec.fp;
						sat_q <= 1'b0;
						ch_q  <= '0;
						rem_q <= '0;
						if (q_rec.mant == '0) begin
							st_q <= B_OUT;
						end else if (!q_rec.pexp[adnp_pkg::PEXP_W-1]) begin
							k_q  <= q_rec.pexp[7:0];
							st_q <= B_UP;
						end else begin
							k_q  <= 8'(-q_rec.pexp);
							st_q <= B_DOWN;
						end
					end
				end
				B_UP: begin
					if (k_q == '0) begin
						st_q <= B_FIT;
					end else if (v_q > lim10) begin
						sat_q <= 1'b1;
						st_q  <= B_OUT;
					end else begin
						k_q <= k_q - 8'd1;
					end
				end
				B_FIT: begin
					if (v_q > limfit) sat_q <= 1'b1;
					st_q <= B_OUT;
				end
				B_DOWN: begin
					if (ch_q == '0 && (k_q == '0 || v_q == '0)) begin
						st_q <= B_CHK;
					end else if (ch_q == 3'(adnp_pkg::CHUNKS - 1)) begin
						ch_q  <= '0;
						rem_q <= '0;
						k_q   <= k_q - 8'd1;
					end else begin
						ch_q  <= ch_q + 3'd1;
						rem_q <= r;
					end
				end
				B_CHK: begin
					if (v_q > lim) sat_q <= 1'b1;
					st_q <= B_OUT;
				end
				B_OUT: begin
					if (load) st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// scaling register
	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				if (q_rec.pexp[adnp_pkg::PEXP_W-1] && q_rec.fp)
					v_q <= VW'(q_rec.mant) << FRAC_BITS;
				else
					v_q <= VW'(q_rec.mant);
				if (q_rec.mant == '0) v_q <= '0;
			end
			B_UP: begin
				if (k_q != '0 && v_q <= lim10) v_q <= (v_q << 3) + (v_q << 1);
			end
			B_FIT: begin
				if (fp_q) v_q <= v_q << FRAC_BITS;
			end
			B_DOWN: begin
				if (!(ch_q == '0 && (k_q == '0 || v_q == '0)))
					v_q <= {v_q[VW-CW-1:0], q};
			end
			default: v_q <= v_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value     <= neg_q ? $signed(-mag_o) : $signed(mag_o);
			saturated <= sat_q;
		end
	end

endmodule

FILE: src/ascii_decimal_number_parser.sv
// Top level of the ASCII decimal number parser.
// Depends on adnp_pkg, adnp_front, adnp_queue and adnp_back.
//
// Text enters one byte per request; the front end takes a byte every cycle
// unless its two-entry number queue is full. A number is closed by the first
// byte that does not fit it (that byte is consumed) or by an end-of-text
// request, and one result request follows: the signed value truncated toward
// zero, a plain integer when integer_only is set, otherwise fixed point with
// FRAC_BITS fraction bits, clamped with saturated set when out of range.
// The back end scales each closed number by its power of ten p (decimal
// point position plus exponent): for p >= 0 it multiplies by ten p times,
// one multiply per cycle, ending early on overflow; for p < 0 it divides by
// ten -p times, each divide taking the 96-bit value twelve bits a cycle,
// ending early once the value reaches zero; a zero mantissa skips scaling.
// The front end takes the next number's bytes while the back end is still
// scaling the last one, as the queue lies between them. Write
// integer_only only while no number is pending.
module ascii_decimal_number_parser #(
	parameter int FRAC_BITS  = adnp_pkg::FRAC_BITS_DEF,
	parameter int MAX_DIGITS = adnp_pkg::MAX_DIGITS_DEF,
	parameter int OUT_BITS   = adnp_pkg::OUT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic                       char_valid,
	output logic                       char_stall,
	input  logic [7:0]                 character,
	input  logic                       end_of_text,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [OUT_BITS-1:0] value,
	output logic                       saturated
);

	logic           integer_only_q;
	logic           q_full, q_push, q_pop, q_not_empty;
	adnp_pkg::rec_t push_rec, pop_rec;

	// mode register, read at every byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) integer_only_q <= 1'b0;
		else if (cfg_we) integer_only_q <= cfg_wdata;
	end

	adnp_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.integer_only (integer_only_q),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.character    (character),
		.end_of_text  (end_of_text),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_rec        (push_rec)
	);

	// decouple byte intake from scaling
	adnp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_rec  (push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_rec   (pop_rec)
	);

	adnp_back #(.FRAC_BITS(FRAC_BITS), .OUT_BITS(OUT_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_rec        (pop_rec),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.saturated    (saturated)
	);

endmodule

FILE: src/adnp_checker.sv
// Port-level checks for the ASCII decimal number parser, bound to the top.
// Depends only on the top level's ports.
module adnp_checker #(
	parameter int OUT_BITS = 32
) (
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_stall,
	input logic [OUT_BITS-1:0] value,
	input logic                saturated
);

	localparam logic [OUT_BITS-1:0] VMAX = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic [OUT_BITS-1:0] VMIN = {1'b1, {(OUT_BITS-1){1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(value) && $stable(saturated))
		else $error("result request changed while stalled");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> (value == VMAX || value == VMIN))
		else $error("saturated result not at a rail");

	a_zero_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && value == '0 |-> !saturated)
		else $error("zero result flagged saturated");

	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !result_valid)
		else $error("result valid right after reset");

endmodule

bind ascii_decimal_number_parser adnp_checker #(.OUT_BITS(OUT_BITS)) u_adnp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.value        (value),
	.saturated    (saturated)
);
